/* hw/rtl/bitmap_frame_allocator_assert.svh */
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_assert.svh
// assertion macros used by the allocator back end (bfa_back)
// ----------------------------------------------------------------------------
`ifndef BITMAP_FRAME_ALLOCATOR_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BFA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("bfa assertion failed");
`define BFA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("bfa assertion failed");
`else
`define BFA_ASSERT(lbl, clk, rst_n, prop)
`define BFA_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* hw/rtl/bfa_pkg.sv */
// ----------------------------------------------------------------------------
// bfa_pkg
// shared types and constants of the bitmap frame allocator
// ----------------------------------------------------------------------------
package bfa_pkg;

    localparam int FRAMES        = 1024;
    localparam int FRM_W         = 10;
    localparam int CNT_W         = 11;
    localparam int JOB_SLOTS     = 16;
    localparam int SLOT_W        = 4;
    localparam int PAGES_PER_JOB = 32;
    localparam int PG_W          = 5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOSPACE  = 3'd1;
    localparam logic [2:0] ST_TOOLARGE = 3'd2;
    localparam logic [2:0] ST_BUSY     = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_BIG     = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [SLOT_W-1:0] slot;
        logic [5:0]        cnt;
    } t_req;

endpackage

/* hw/rtl/bfa_front.sv */
// ----------------------------------------------------------------------------
// bfa_front
// takes request words, tags them by kind and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module bfa_front import bfa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_req_type,
    input  logic [3:0]  i_job_slot,
    input  logic [5:0]  i_page_count,
    input  logic        i_clearing,
    output logic        o_q_vld,
    output t_req        o_q_req,
    input  logic        i_q_pop
);

    t_req       r_ent [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       n_wp;
    logic       n_rp;
    logic [1:0] n_cnt;
    logic       wr;
    logic       rd;
    t_req       req;

    always_comb begin
        req.slot = i_job_slot;
        req.cnt  = i_page_count;
        if (i_req_type) begin
            req.op = OP_RELEASE;
        end else if (i_page_count > 6'(PAGES_PER_JOB)) begin
            req.op = OP_BIG;
        end else begin
            req.op = OP_ALLOC;
        end
    end

    assign o_full  = (r_cnt == 2'd2) || i_clearing;
    assign o_q_vld = (r_cnt != 2'd0);
    assign o_q_req = r_ent[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_q_pop && o_q_vld;

    always_comb begin
        n_wp  = wr ? !r_wp : r_wp;
        n_rp  = rd ? !r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, wr} - {1'b0, rd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (wr) begin
            r_ent[r_wp] <= req;
        end
    end

endmodule

/* hw/rtl/bfa_back.sv */
// ----------------------------------------------------------------------------
// bfa_back
// runs requests against the frame bitmap and page tables, drives result words
// ----------------------------------------------------------------------------
`include "bitmap_frame_allocator_assert.svh"
module bfa_back import bfa_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CNT_W-1:0] i_eff,
    output logic             o_clearing,
    input  logic             i_q_vld,
    input  t_req             i_q_req,
    output logic             o_q_pop,
    output logic             o_empty,
    input  logic             i_pop,
    output logic [2:0]       o_status,
    output logic             o_frame_valid,
    output logic [5:0]       o_page_number,
    output logic [9:0]       o_frame,
    output logic [10:0]      o_free_count,
    output logic             o_last
);

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_CHECK  = 4'd2;
    localparam logic [3:0] S_COUNT  = 4'd3;
    localparam logic [3:0] S_DECIDE = 4'd4;
    localparam logic [3:0] S_EMIT   = 4'd5;
    localparam logic [3:0] S_ARD    = 4'd6;
    localparam logic [3:0] S_AEV    = 4'd7;
    localparam logic [3:0] S_RRD    = 4'd8;
    localparam logic [3:0] S_RWR    = 4'd9;

    logic [3:0]        r_state, n_state;
    t_req              r_req, n_req;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_free, n_free;
    logic              r_cv, n_cv;
    logic [2:0]        r_st, n_st;
    logic [5:0]        r_got, n_got;
    logic [5:0]        r_np, n_np;
    logic [JOB_SLOTS-1:0] r_busy, n_busy;
    logic [5:0]        r_pages [JOB_SLOTS];
    logic              pages_we;

    logic              r_ovld;
    logic [2:0]        r_ostatus;
    logic              r_ofv;
    logic [5:0]        r_opg;
    logic [9:0]        r_ofr;
    logic [10:0]       r_ofc;
    logic              r_olast;

    logic              ld;
    logic [2:0]        ld_st;
    logic              ld_fv;
    logic [5:0]        ld_pg;
    logic [9:0]        ld_fr;
    logic [10:0]       ld_fc;
    logic              ld_last;
    logic              out_free;

    logic              mem_map [FRAMES];
    logic              map_q;
    logic              map_we;
    logic [FRM_W-1:0]  map_wa;
    logic              map_wd;
    logic [FRM_W-1:0]  pf_mem [JOB_SLOTS*PAGES_PER_JOB];
    logic [FRM_W-1:0]  pf_q;
    logic              pf_we;

    assign out_free   = !r_ovld || i_pop;
    assign o_clearing = (r_state == S_CLR);

    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_idx    = r_idx;
        n_free   = r_free;
        n_cv     = 1'b0;
        n_st     = r_st;
        n_got    = r_got;
        n_np     = r_np;
        n_busy   = r_busy;
        pages_we = 1'b0;
        o_q_pop  = 1'b0;
        map_we   = 1'b0;
        map_wa   = r_idx[FRM_W-1:0];
        map_wd   = 1'b0;
        pf_we    = 1'b0;
        ld       = 1'b0;
        ld_st    = r_st;
        ld_fv    = 1'b0;
        ld_pg    = 6'd0;
        ld_fr    = 10'd0;
        ld_fc    = r_free;
        ld_last  = 1'b1;
        unique case (r_state)
            S_CLR: begin
                map_we = 1'b1;
                n_idx  = r_idx + 11'd1;
                if (r_idx == CNT_W'(FRAMES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_vld) begin
                    o_q_pop = 1'b1;
                    n_req   = i_q_req;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_idx   = '0;
                n_free  = '0;
                n_state = S_COUNT;
                unique case (r_req.op)
                    OP_RELEASE: begin
                        if (!r_busy[r_req.slot]) begin
                            n_st = ST_EMPTY;
                        end else begin
                            n_st   = ST_OK;
                            n_np   = r_pages[r_req.slot];
                            n_busy[r_req.slot] = 1'b0;
                            if (r_pages[r_req.slot] != 6'd0) begin
                                n_state = S_RRD;
                            end
                        end
                    end
                    OP_BIG: n_st = ST_TOOLARGE;
                    default: n_st = r_busy[r_req.slot] ? ST_BUSY : ST_OK;
                endcase
            end
            S_COUNT: begin
                if (r_cv && !map_q) begin
                    n_free = r_free + 11'd1;
                end
                if (r_idx < i_eff) begin
                    n_cv  = 1'b1;
                    n_idx = r_idx + 11'd1;
                end else if (!r_cv) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_EMIT;
                if (r_req.op == OP_ALLOC && r_st == ST_OK) begin
                    if (r_free < {5'd0, r_req.cnt}) begin
                        n_st = ST_NOSPACE;
                    end else begin
                        n_busy[r_req.slot] = 1'b1;
                        pages_we = 1'b1;
                        if (r_req.cnt != 6'd0) begin
                            n_free  = r_free - {5'd0, r_req.cnt};
                            n_idx   = '0;
                            n_got   = 6'd0;
                            n_state = S_ARD;
                        end
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    ld      = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_ARD: begin
                n_state = S_AEV;
            end
            S_AEV: begin
                if (map_q) begin
                    n_idx   = r_idx + 11'd1;
                    n_state = S_ARD;
                end else if (out_free) begin
                    map_we  = 1'b1;
                    map_wd  = 1'b1;
                    pf_we   = 1'b1;
                    ld      = 1'b1;
                    ld_fv   = 1'b1;
                    ld_pg   = r_got + 6'd1;
                    ld_fr   = r_idx[FRM_W-1:0];
                    ld_last = (r_got + 6'd1 == r_req.cnt);
                    n_got   = r_got + 6'd1;
                    n_idx   = r_idx + 11'd1;
                    n_state = ld_last ? S_IDLE : S_ARD;
                end
            end
            S_RRD: begin
                n_state = S_RWR;
            end
            S_RWR: begin
                map_we = 1'b1;
                map_wa = pf_q;
                if (r_idx[5:0] + 6'd1 == r_np) begin
                    n_idx   = '0;
                    n_free  = '0;
                    n_state = S_COUNT;
                end else begin
                    n_idx   = r_idx + 11'd1;
                    n_state = S_RRD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_idx   <= '0;
            r_cv    <= 1'b0;
            r_busy  <= '0;
            r_ovld  <= 1'b0;
            for (int k = 0; k < JOB_SLOTS; k++) begin
                r_pages[k] <= 6'd0;
            end
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_cv    <= n_cv;
            r_busy  <= n_busy;
            if (pages_we) begin
                r_pages[r_req.slot] <= r_req.cnt;
            end
            if (ld) begin
                r_ovld <= 1'b1;
            end else if (i_pop) begin
                r_ovld <= 1'b0;
            end
        end
        r_req  <= n_req;
        r_free <= n_free;
        r_st   <= n_st;
        r_got  <= n_got;
        r_np   <= n_np;
        if (ld) begin
            r_ostatus <= ld_st;
            r_ofv     <= ld_fv;
            r_opg     <= ld_pg;
            r_ofr     <= ld_fr;
            r_ofc     <= ld_fc;
            r_olast   <= ld_last;
        end
    end

    // frame bitmap, one bit per frame
    always_ff @(posedge i_clk) begin
        if (map_we) begin
            mem_map[map_wa] <= map_wd;
        end
        map_q <= mem_map[r_idx[FRM_W-1:0]];
    end

    // per-slot page tables
    always_ff @(posedge i_clk) begin
        if (pf_we) begin
            pf_mem[{r_req.slot, r_got[PG_W-1:0]}] <= r_idx[FRM_W-1:0];
        end
        pf_q <= pf_mem[{r_req.slot, r_idx[PG_W-1:0]}];
    end

    assign o_empty       = !r_ovld;
    assign o_status      = r_ostatus;
    assign o_frame_valid = r_ofv;
    assign o_page_number = r_opg;
    assign o_frame       = r_ofr;
    assign o_free_count  = r_ofc;
    assign o_last        = r_olast;

    `BFA_ASSERT(a_alloc_emits, i_clk, i_rst_n, (r_state == S_AEV && !map_q && out_free) |=> r_ovld)
    `BFA_ASSERT(a_count_bound, i_clk, i_rst_n, (r_state == S_COUNT) |-> (r_free <= i_eff))
    `BFA_ASSERT(a_alloc_short, i_clk, i_rst_n, (r_state == S_ARD) |-> (r_got < r_req.cnt))
    `BFA_ASSERT(a_no_pop_clear, i_clk, i_rst_n, (r_state == S_CLR) |-> !o_q_pop)

endmodule

/* hw/rtl/bitmap_frame_allocator.sv */
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// page frame allocator over a free bitmap, with per-slot page tables
//
//   channel   handshake          ports
//   request   i_push / o_full    i_req_type i_job_slot i_page_count
//   result    o_empty / i_pop    o_status o_frame_valid o_page_number
//                                o_frame o_free_count o_last
//   config    i_cfg_we           i_cfg_wdata (block count)
//
// after reset the bitmap is cleared, o_full stays high then
// each request counts free frames over the block count, one bitmap bit a cycle
// an allocation then scans the bitmap again, a read and an evaluate state per frame visited
// a release walks the slot's pages, a read and a write state per page, before the count
// a result waiting in the output register stalls the allocation scan
// ----------------------------------------------------------------------------
module bitmap_frame_allocator import bfa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_req_type,
    input  logic [3:0]  i_job_slot,
    input  logic [5:0]  i_page_count,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [2:0]  o_status,
    output logic        o_frame_valid,
    output logic [5:0]  o_page_number,
    output logic [9:0]  o_frame,
    output logic [10:0] o_free_count,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata
);

    logic [CNT_W-1:0] r_block_count;
    logic [CNT_W-1:0] eff;
    logic             clearing;
    logic             q_vld;
    logic             q_pop;
    t_req             q_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= CNT_W'(FRAMES);
        end else if (i_cfg_we) begin
            r_block_count <= i_cfg_wdata;
        end
    end

    always_comb begin
        if (r_block_count == '0) begin
            eff = CNT_W'(1);
        end else if (r_block_count > CNT_W'(FRAMES)) begin
            eff = CNT_W'(FRAMES);
        end else begin
            eff = r_block_count;
        end
    end

    bfa_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_req_type   (i_req_type),
        .i_job_slot   (i_job_slot),
        .i_page_count (i_page_count),
        .i_clearing   (clearing),
        .o_q_vld      (q_vld),
        .o_q_req      (q_req),
        .i_q_pop      (q_pop)
    );

    bfa_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_eff         (eff),
        .o_clearing    (clearing),
        .i_q_vld       (q_vld),
        .i_q_req       (q_req),
        .o_q_pop       (q_pop),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_status      (o_status),
        .o_frame_valid (o_frame_valid),
        .o_page_number (o_page_number),
        .o_frame       (o_frame),
        .o_free_count  (o_free_count),
        .o_last        (o_last)
    );

endmodule
